>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the console writer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TMCW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TMCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Item types, configuration types, character codes and controller states.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } cmd_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [10:0] cursor_position;
  } res_t;

  typedef struct packed {
    logic [7:0] text_attribute;
    logic       console_enable;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } tmcw_state_t;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic CFG_TEXT_ATTR  = 1'b0;
  localparam logic CFG_CONSOLE_EN = 1'b1;

  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [15:0] RESET_CELL  = 16'h0720;
  localparam logic [7:0]  ATTR_RESET  = 8'h07;
  localparam int unsigned TAB_STEP    = 8;

endpackage

>>> hw/rtl/text_mode_console_writer.sv
// ----------------------------------------------------------------------------
// Text mode console writer
// Character-cell console with a cursor, control codes and scrolling.
// ----------------------------------------------------------------------------
// After reset the block fills every cell of the store with a blank cell and
// accepts no item meanwhile; configuration writes are taken at any time. A
// read item or a put that stays on the screen goes to the completion state,
// which loads its result once the output register is free. A put that moves
// the cursor past the last row scrolls the store through its single read and
// write port, one cell per cycle. One item is in work at a time, and a
// finished result waits in the output register while the next item is taken.
module text_mode_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tmcw_pkg::cmd_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tmcw_pkg::res_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data
);

  import tmcw_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_ATTR:  cfg_nxt.text_attribute = cfg_data;
        CFG_CONSOLE_EN: cfg_nxt.console_enable = cfg_data[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_attribute <= ATTR_RESET;
      cfg_r.console_enable <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tmcw_ctrl #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

>>> hw/rtl/tmcw_cell_ram.sv
// ----------------------------------------------------------------------------
// Cell store
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tmcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data
);

  logic [15:0] mem_r [DEPTH];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/tmcw_ctrl.sv
// ----------------------------------------------------------------------------
// Console controller
// Cursor, item sequencing, scroll sweep and result register around the store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tmcw_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  tmcw_pkg::cmd_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tmcw_pkg::res_t out_data
);

  import tmcw_pkg::*;

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int AW       = $clog2(CELLS);
  localparam int NW       = $clog2(CELLS + 1);
  localparam int CW       = $clog2(COLUMNS);
  localparam int LW       = $clog2(ROWS);
  localparam int TW       = $clog2(COLUMNS + 8);
  localparam int COPY_LEN = CELLS - COLUMNS;

  localparam logic [NW-1:0] CNT_COPY_END = NW'(COPY_LEN);
  localparam logic [NW-1:0] CNT_LAST     = NW'(CELLS - 1);
  localparam logic [NW-1:0] CNT_COLS     = NW'(COLUMNS);
  localparam logic [TW-1:0] COLS_T       = TW'(COLUMNS);
  localparam logic [LW-1:0] LAST_LINE    = LW'(ROWS - 1);
  localparam logic [6:0]    ROWS_L       = 7'(ROWS);
  localparam logic [7:0]    COLS_L       = 8'(COLUMNS);

  tmcw_state_t state_r, state_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [LW-1:0] line_r, line_nxt;
  logic          is_read_r, is_read_nxt;
  logic          rd_zero_r, rd_zero_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_data_r, out_data_nxt;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  logic          acc;
  logic          out_free;
  logic [AW-1:0] cur_idx;
  logic [AW+10:0] pos_ext;
  logic [AW-1:0] rd_lin;
  logic          rd_in_range;
  logic [15:0]   blank;
  logic [TW-1:0] col_inc;
  logic [TW-1:0] tab_col;

  logic          p_wr;
  logic [AW-1:0] p_wr_addr;
  logic [15:0]   p_wr_data;
  logic [CW-1:0] p_col;
  logic [LW-1:0] p_line;
  logic          p_scroll;

  tmcw_cell_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  assign in_ready    = (state_r == ST_IDLE);
  assign acc         = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign cur_idx     = AW'(AW'(line_r) * AW'(COLUMNS) + AW'(col_r));
  assign pos_ext     = {11'b0, cur_idx};
  assign rd_lin      = AW'(AW'(in_data.read_row) * AW'(COLUMNS) + AW'(in_data.read_column));
  assign rd_in_range = ({2'b0, in_data.read_row} < ROWS_L) &&
                       ({1'b0, in_data.read_column} < COLS_L);
  assign blank       = {cfg.text_attribute, CHAR_SPACE};
  assign col_inc     = TW'(col_r) + TW'(1);
  assign tab_col     = (TW'(col_r) + TW'(TAB_STEP)) & ~TW'(TAB_STEP - 1);

  always_comb begin
    logic adv;
    adv       = 1'b0;
    p_wr      = 1'b0;
    p_wr_addr = cur_idx;
    p_wr_data = {cfg.text_attribute, in_data.char_code};
    p_col     = col_r;
    p_line    = line_r;
    p_scroll  = 1'b0;
    case (in_data.char_code)
      CHAR_NL: begin
        adv = 1'b1;
      end
      CHAR_CR: begin
        p_col = '0;
      end
      CHAR_BS: begin
        if (col_r != '0) begin
          p_col     = col_r - CW'(1);
          p_wr      = 1'b1;
          p_wr_addr = cur_idx - AW'(1);
          p_wr_data = blank;
        end
      end
      CHAR_TAB: begin
        if (tab_col >= COLS_T) begin
          adv = 1'b1;
        end else begin
          p_col = CW'(tab_col);
        end
      end
      default: begin
        p_wr = 1'b1;
        if (col_inc >= COLS_T) begin
          adv = 1'b1;
        end else begin
          p_col = CW'(col_inc);
        end
      end
    endcase
    if (adv) begin
      p_col = '0;
      if (line_r == LAST_LINE) begin
        p_scroll = 1'b1;
      end else begin
        p_line = line_r + LW'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          if (in_data.opcode == OP_PUT && cfg.console_enable && p_scroll) begin
            state_nxt = ST_SCROLL;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCROLL: begin
        if (cnt_r == CNT_COPY_END) begin
          state_nxt = ST_BLANK;
        end
      end
      ST_BLANK: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = rd_lin;
    wr_en         = 1'b0;
    wr_addr       = AW'(cnt_r);
    wr_data       = blank;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    is_read_nxt   = is_read_r;
    rd_zero_nxt   = rd_zero_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = RESET_CELL;
        cnt_nxt = (cnt_r == CNT_LAST) ? '0 : cnt_r + NW'(1);
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        if (acc) begin
          if (in_data.opcode == OP_READ) begin
            rd_en       = 1'b1;
            is_read_nxt = 1'b1;
            rd_zero_nxt = !rd_in_range;
          end else begin
            is_read_nxt = 1'b0;
            if (cfg.console_enable) begin
              wr_en    = p_wr;
              wr_addr  = p_wr_addr;
              wr_data  = p_wr_data;
              col_nxt  = p_col;
              line_nxt = p_line;
            end
          end
        end
      end
      ST_SCROLL: begin
        if (cnt_r != CNT_COPY_END) begin
          rd_en   = 1'b1;
          rd_addr = AW'(cnt_r + CNT_COLS);
          cnt_nxt = cnt_r + NW'(1);
        end
        if (cnt_r != '0) begin
          wr_en   = 1'b1;
          wr_addr = AW'(cnt_r - NW'(1));
          wr_data = rd_data;
        end
      end
      ST_BLANK: begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + NW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.cell_value      = (is_read_r && !rd_zero_r) ? rd_data : 16'h0000;
          out_data_nxt.cursor_position = pos_ext[10:0];
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      col_r       <= '0;
      line_r      <= '0;
      is_read_r   <= 1'b0;
      rd_zero_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      is_read_r   <= is_read_nxt;
      rd_zero_r   <= rd_zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TMCW_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> state_r == ST_CLEAR, "reset must start the clearing pass")
  `TMCW_ASSERT(a_col_range, clk, rst_n, {1'b0, col_r} < {1'b0, COLS_T}, "cursor column out of range")
  `TMCW_ASSERT(a_line_range, clk, rst_n, line_r <= LAST_LINE, "cursor line out of range")
  `TMCW_ASSERT(a_result_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r) == ST_DONE, "result loaded outside completion")
  `TMCW_ASSERT(a_no_result_in_clear, clk, rst_n, state_r == ST_CLEAR |-> !out_valid_r, "result present during clearing pass")

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Text mode console writer testbench
// Drives put and read items through the valid/ready channels with random
// gaps and stalls on both sides, and compares every result with the script's
// value or a model of the console that tracks the cursor, the cell store and the registers. A
// short directed script covers field extremes, control codes, out of range
// reads and a disabled console. Random phases with different attributes
// follow, and the enable is toggled between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tmcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  typedef struct packed {
    logic       is_reg;
    logic       reg_index;
    logic [7:0] reg_value;
    cmd_t       cmd;
    res_t       want;
  } script_row_t;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  cmd_t in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_data;
  logic cfg_we    = 1'b0;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  logic [15:0] screen [COLUMNS*ROWS];
  int          cursor_col;
  int          cursor_line;
  logic [7:0]  shadow_attr;
  logic        shadow_enable;

  res_t        pending_results [$];
  res_t        oldest_result;
  int          error_count = 0;
  bit          calm = 1'b0;
  script_row_t script [28];

  text_mode_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void next_line();
    cursor_col = 0;
    cursor_line++;
    if (cursor_line >= ROWS) begin
      for (int i = 0; i < COLUMNS*(ROWS-1); i++) begin
        screen[i] = screen[i+COLUMNS];
      end
      for (int i = COLUMNS*(ROWS-1); i < COLUMNS*ROWS; i++) begin
        screen[i] = {shadow_attr, CHAR_SPACE};
      end
      cursor_line = ROWS - 1;
    end
  endfunction

  function automatic res_t console_step(input cmd_t c);
    res_t r;
    r = '0;
    if (c.opcode == OP_READ) begin
      if (c.read_row < ROWS && c.read_column < COLUMNS) begin
        r.cell_value = screen[c.read_row*COLUMNS + c.read_column];
      end
    end else if (shadow_enable) begin
      case (c.char_code)
        CHAR_NL: next_line();
        CHAR_CR: cursor_col = 0;
        CHAR_BS: begin
          if (cursor_col > 0) begin
            cursor_col--;
            screen[cursor_line*COLUMNS + cursor_col] = {shadow_attr, CHAR_SPACE};
          end
        end
        CHAR_TAB: begin
          cursor_col = (cursor_col + TAB_STEP) & ~(TAB_STEP - 1);
          if (cursor_col >= COLUMNS) next_line();
        end
        default: begin
          screen[cursor_line*COLUMNS + cursor_col] = {shadow_attr, c.char_code};
          cursor_col++;
          if (cursor_col >= COLUMNS) next_line();
        end
      endcase
    end
    r.cursor_position = 11'(cursor_line*COLUMNS + cursor_col);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int   pick;
    c = $bits(cmd_t)'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      c.opcode = OP_READ;
      if ($urandom_range(0, 9) != 0) begin
        c.read_column = 7'($urandom_range(0, COLUMNS-1));
        if ($urandom_range(0, 1) == 0) begin
          c.read_row = 5'(cursor_line);
        end else begin
          c.read_row = 5'($urandom_range(0, ROWS-1));
        end
      end
    end else begin
      c.opcode = OP_PUT;
      if (pick < 36) c.char_code = CHAR_NL;
      else if (pick < 40) c.char_code = CHAR_CR;
      else if (pick < 46) c.char_code = CHAR_BS;
      else if (pick < 52) c.char_code = CHAR_TAB;
      else if (pick < 75) c.char_code = 8'($urandom_range(32, 126));
    end
    return c;
  endfunction

  function automatic script_row_t put_row(input logic [7:0] ch, input int pos);
    script_row_t r;
    r = '0;
    r.cmd.opcode = OP_PUT;
    r.cmd.char_code = ch;
    r.want.cursor_position = 11'(pos);
    return r;
  endfunction

  function automatic script_row_t peek_row(input int row, input int col,
                                           input logic [15:0] cell_val, input int pos);
    script_row_t r;
    r = '0;
    r.cmd.opcode = OP_READ;
    r.cmd.read_row = 5'(row);
    r.cmd.read_column = 7'(col);
    r.want.cell_value = cell_val;
    r.want.cursor_position = 11'(pos);
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic idx, input logic [7:0] val);
    script_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    in_valid <= 1'b0;
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TEXT_ATTR:  shadow_attr = val;
      CFG_CONSOLE_EN: shadow_enable = val[0];
      default:        shadow_attr = shadow_attr;
    endcase
  endtask

  task automatic send_item(input cmd_t c, input logic typed, input res_t want);
    int   gap;
    res_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = console_step(c);
    pending_results.push_back(typed ? want : predicted);
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.cell_value !== oldest_result.cell_value) begin
          $display("%0t: cell_value mismatch, expected %h, got %h", $time,
                   oldest_result.cell_value, out_data.cell_value);
          error_count++;
        end
        if (out_data.cursor_position !== oldest_result.cursor_position) begin
          $display("%0t: cursor_position mismatch, expected %0d, got %0d", $time,
                   oldest_result.cursor_position, out_data.cursor_position);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int count;
    for (int i = 0; i < COLUMNS*ROWS; i++) screen[i] = RESET_CELL;
    cursor_col = 0;
    cursor_line = 0;
    shadow_attr = ATTR_RESET;
    shadow_enable = 1'b1;
    script = '{
      peek_row(0, 0, 16'h0720, 0),
      peek_row(24, 79, 16'h0720, 0),
      peek_row(25, 0, 16'h0000, 0),
      peek_row(31, 127, 16'h0000, 0),
      peek_row(0, 80, 16'h0000, 0),
      put_row(CHAR_BS, 0),
      put_row(8'h41, 1),
      put_row(8'hFF, 2),
      put_row(8'h00, 3),
      peek_row(0, 1, 16'h07FF, 3),
      put_row(CHAR_TAB, 8),
      put_row(CHAR_BS, 7),
      peek_row(0, 7, 16'h0720, 7),
      put_row(CHAR_CR, 0),
      put_row(CHAR_NL, 80),
      peek_row(0, 0, 16'h0741, 80),
      peek_row(0, 2, 16'h0700, 80),
      reg_row(CFG_CONSOLE_EN, 8'h00),
      put_row(8'h5A, 80),
      put_row(CHAR_NL, 80),
      peek_row(0, 0, 16'h0741, 80),
      reg_row(CFG_TEXT_ATTR, 8'hFF),
      reg_row(CFG_CONSOLE_EN, 8'h01),
      put_row(8'h42, 81),
      peek_row(1, 0, 16'hFF42, 81),
      reg_row(CFG_TEXT_ATTR, 8'h00),
      put_row(CHAR_BS, 80),
      peek_row(1, 0, 16'h0020, 80)
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        write_reg(script[i].reg_index, script[i].reg_value);
      end else begin
        send_item(script[i].cmd, 1'b1, script[i].want);
      end
    end

    for (int phase = 0; phase < 11; phase++) begin
      calm = (phase % 4 == 2);
      write_reg(CFG_TEXT_ATTR, 8'($urandom));
      write_reg(CFG_CONSOLE_EN, (phase == 5) ? 8'h00 : 8'h01);
      count = (phase == 5) ? 40 : 130;
      repeat (count) send_item(random_command(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> text_mode_console_writer.f
+incdir+hw/rtl
hw/rtl/tmcw_pkg.sv
hw/rtl/tmcw_cell_ram.sv
hw/rtl/tmcw_ctrl.sv
hw/rtl/text_mode_console_writer.sv
tb/tb.sv
